// ----- hdl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int PRIO_W         = 16;
	localparam int DATA_W         = 32;
	localparam int OCC_W          = 5;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DROP  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-cycle command to the cell row
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/spq_cell.sv -----
`default_nettype none
module spq_cell #(
	parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
	input  wire                               clk,
	input  wire spq_pkg::cell_ctrl_t          ctrl,
	input  wire                               occ,
	input  wire        [VALUE_BITS-1:0]       new_val,
	input  wire signed [spq_pkg::PRIO_W-1:0]  new_pri,
	input  wire                               left_ge,
	input  wire        [VALUE_BITS-1:0]       left_val,
	input  wire signed [spq_pkg::PRIO_W-1:0]  left_pri,
	input  wire        [VALUE_BITS-1:0]       right_val,
	input  wire signed [spq_pkg::PRIO_W-1:0]  right_pri,
	output logic                              ge,
	output logic       [VALUE_BITS-1:0]       val,
	output logic signed [spq_pkg::PRIO_W-1:0] pri
);

	logic        [VALUE_BITS-1:0]      val_q;
	logic signed [spq_pkg::PRIO_W-1:0] pri_q;

	// entry stays ahead of the new word
	assign ge  = occ && (pri_q >= new_pri);
	assign val = val_q;
	assign pri = pri_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && !ge) begin
			if (left_ge) begin
				val_q <= new_val;
				pri_q <= new_pri;
			end else begin
				val_q <= left_val;
				pri_q <= left_pri;
			end
		end else if (ctrl.pop) begin
			val_q <= right_val;
			pri_q <= right_pri;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
`default_nettype none
// channel  words                                   handshake
// in       cmd, value_in, prio_in                  cmd_valid / cmd_stall
// out      value_out, status, occupancy,           res_valid / res_stall
//          is_full, is_empty
//
// One word per cycle: the row of cells compares and shifts in the cycle a
// command is taken, the result is registered and shows in the next cycle.
// A held-off result stalls the input until it is taken; a result taken in
// the same cycle lets the next word in.
// Reset empties the queue at once; cell contents are not cleared.
module sorted_priority_queue #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cmd_valid,
	output logic                               cmd_stall,
	input  wire        [1:0]                   cmd,
	input  wire        [spq_pkg::DATA_W-1:0]   value_in,
	input  wire signed [spq_pkg::PRIO_W-1:0]   prio_in,
	output logic                               res_valid,
	input  wire                                res_stall,
	output logic       [spq_pkg::DATA_W-1:0]   value_out,
	output logic       [1:0]                   status,
	output logic       [spq_pkg::OCC_W-1:0]    occupancy,
	output logic                               is_full,
	output logic                               is_empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                       accept;
	spq_pkg::cmd_t              op;
	spq_pkg::cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           count_nxt;
	spq_pkg::status_t           st_nxt;
	logic [spq_pkg::DATA_W-1:0] val_nxt;
	logic                       full_now;
	logic                       empty_now;
	logic [VALUE_BITS-1:0]      new_val;

	logic                              ge   [DEPTH];
	logic        [VALUE_BITS-1:0]      cval [DEPTH];
	logic signed [spq_pkg::PRIO_W-1:0] cpri [DEPTH];

	logic                       res_valid_q;
	logic [spq_pkg::DATA_W-1:0] value_q;
	spq_pkg::status_t           status_q;
	logic [CNT_W-1:0]           occ_q;

	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign op        = spq_pkg::cmd_t'(cmd);
	assign full_now  = (count_q == CNT_W'(DEPTH));
	assign empty_now = (count_q == '0);
	assign new_val   = VALUE_BITS'(value_in);

	always_comb begin
		ctrl      = '0;
		count_nxt = count_q;
		st_nxt    = spq_pkg::ST_OK;
		val_nxt   = '0;
		case (op)
			spq_pkg::CMD_ENQ: begin
				if (full_now) begin
					st_nxt = spq_pkg::ST_DROP;
				end else begin
					ctrl.insert = accept;
					count_nxt   = count_q + 1'b1;
				end
			end
			spq_pkg::CMD_DEQ: begin
				if (empty_now) begin
					st_nxt = spq_pkg::ST_EMPTY;
				end else begin
					ctrl.pop  = accept;
					val_nxt   = spq_pkg::DATA_W'(cval[0]);
					count_nxt = count_q - 1'b1;
				end
			end
			spq_pkg::CMD_PEEK: begin
				if (empty_now) begin
					st_nxt = spq_pkg::ST_EMPTY;
				end else begin
					val_nxt = spq_pkg::DATA_W'(cval[0]);
				end
			end
			spq_pkg::CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                              l_ge;
		logic        [VALUE_BITS-1:0]      l_val;
		logic signed [spq_pkg::PRIO_W-1:0] l_pri;
		logic        [VALUE_BITS-1:0]      r_val;
		logic signed [spq_pkg::PRIO_W-1:0] r_pri;

		if (i == 0) begin : g_first
			assign l_ge  = 1'b1;
			assign l_val = '0;
			assign l_pri = '0;
		end else begin : g_mid
			assign l_ge  = ge[i-1];
			assign l_val = cval[i-1];
			assign l_pri = cpri[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_val = cval[i];
			assign r_pri = cpri[i];
		end else begin : g_inner
			assign r_val = cval[i+1];
			assign r_pri = cpri[i+1];
		end

		spq_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (count_q > CNT_W'(i)),
			.new_val   (new_val),
			.new_pri   (prio_in),
			.left_ge   (l_ge),
			.left_val  (l_val),
			.left_pri  (l_pri),
			.right_val (r_val),
			.right_pri (r_pri),
			.ge        (ge[i]),
			.val       (cval[i]),
			.pri       (cpri[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= val_nxt;
			status_q <= st_nxt;
			occ_q    <= count_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign value_out = value_q;
	assign status    = status_q;
	assign occupancy = spq_pkg::OCC_W'(occ_q);
	assign is_full   = (occ_q == CNT_W'(DEPTH));
	assign is_empty  = (occ_q == '0);

endmodule
`default_nettype wire

// ----- dv/sorted_priority_queue_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module sorted_priority_queue_tb;

	localparam int QDEPTH       = spq_pkg::DEPTH_DEF;
	localparam int RANDOM_WORDS = 800;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct {
		logic [spq_pkg::DATA_W-1:0] value;
		spq_pkg::status_t           st;
		logic [spq_pkg::OCC_W-1:0]  occ;
		logic                       full;
		logic                       empty;
	} pq_result_t;

	// shadow of the sorted array plus the results still owed by the block
	class prio_queue_sb_t;
		logic [spq_pkg::DATA_W-1:0]        shadow_val[QDEPTH];
		logic signed [spq_pkg::PRIO_W-1:0] shadow_prio[QDEPTH];
		int                                held;
		pq_result_t                        due_results[$];
		int                                mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function int pending_count();
			return due_results.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void note_cmd(spq_pkg::cmd_t c, logic [spq_pkg::DATA_W-1:0] v,
			logic signed [spq_pkg::PRIO_W-1:0] p);
			pq_result_t r;
			int         pos;
			r.value = '0;
			r.st    = spq_pkg::ST_OK;
			case (c)
				spq_pkg::CMD_ENQ: begin
					if (held >= QDEPTH) begin
						r.st = spq_pkg::ST_DROP;
					end else begin
						pos = 0;
						while (pos < held && shadow_prio[pos] >= p)
							pos++;
						for (int k = held; k > pos; k--) begin
							shadow_val[k]  = shadow_val[k-1];
							shadow_prio[k] = shadow_prio[k-1];
						end
						shadow_val[pos]  = v;
						shadow_prio[pos] = p;
						held++;
					end
				end
				spq_pkg::CMD_DEQ: begin
					if (held == 0) begin
						r.st = spq_pkg::ST_EMPTY;
					end else begin
						r.value = shadow_val[0];
						for (int k = 0; k + 1 < held; k++) begin
							shadow_val[k]  = shadow_val[k+1];
							shadow_prio[k] = shadow_prio[k+1];
						end
						held--;
					end
				end
				spq_pkg::CMD_PEEK: begin
					if (held == 0)
						r.st = spq_pkg::ST_EMPTY;
					else
						r.value = shadow_val[0];
				end
				default: begin
					held = 0;
				end
			endcase
			r.occ   = held[spq_pkg::OCC_W-1:0];
			r.full  = (held >= QDEPTH);
			r.empty = (held == 0);
			due_results.push_back(r);
		endfunction

		function void check_result(logic [spq_pkg::DATA_W-1:0] v, logic [1:0] st,
			logic [spq_pkg::OCC_W-1:0] occ, logic full, logic empty);
			pq_result_t e;
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected word value %h status %0d occ %0d", v, st, occ));
				return;
			end
			e = due_results.pop_front();
			if (v !== e.value || st !== e.st || occ !== e.occ || full !== e.full
					|| empty !== e.empty)
				flag($sformatf({"exp value %h status %0d occ %0d full %b empty %b, ",
					"got value %h status %0d occ %0d full %b empty %b"},
					e.value, e.st, e.occ, e.full, e.empty, v, st, occ, full, empty));
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cmd_valid;
	logic                              cmd_stall;
	logic [1:0]                        cmd;
	logic [spq_pkg::DATA_W-1:0]        value_in;
	logic signed [spq_pkg::PRIO_W-1:0] prio_in;
	logic                              res_valid;
	logic                              res_stall;
	logic [spq_pkg::DATA_W-1:0]        value_out;
	logic [1:0]                        status;
	logic [spq_pkg::OCC_W-1:0]         occupancy;
	logic                              is_full;
	logic                              is_empty;

	prio_queue_sb_t sb = new();
	bit             hold_req = 1'b0;
	int             burst_left = 0;
	int             cycle_count = 0;

	sorted_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.value_in  (value_in),
		.prio_in   (prio_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value_out (value_out),
		.status    (status),
		.occupancy (occupancy),
		.is_full   (is_full),
		.is_empty  (is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(value_out, status, occupancy, is_full, is_empty);
	end

	// receiver: random stall segments, plus a long hold-off on request
	initial begin
		int seg_left;
		int mode;
		int hold_left;
		seg_left  = 0;
		mode      = 0;
		hold_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(1, 60);
				end
				seg_left--;
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 3) != 0);
					default: res_stall <= ~res_stall;
				endcase
			end
		end
	end

	task automatic idle(int n);
		cmd_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_word(spq_pkg::cmd_t c, logic [spq_pkg::DATA_W-1:0] v,
		logic signed [spq_pkg::PRIO_W-1:0] p);
		cmd_valid <= 1'b1;
		cmd       <= c;
		value_in  <= v;
		prio_in   <= p;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c, v, p);
	endtask

	task automatic offer(spq_pkg::cmd_t c, logic [spq_pkg::DATA_W-1:0] v,
		logic signed [spq_pkg::PRIO_W-1:0] p);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 8));
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		send_word(c, v, p);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
		burst_left = 0;
	endtask

	task automatic offer_random(int kind);
		int                                r;
		spq_pkg::cmd_t                     c;
		logic [spq_pkg::DATA_W-1:0]        v;
		logic signed [spq_pkg::PRIO_W-1:0] p;
		r = $urandom_range(0, 99);
		case (kind)
			0:       c = (r < 75) ? spq_pkg::CMD_ENQ : (r < 90) ? spq_pkg::CMD_DEQ :
				(r < 98) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
			1:       c = (r < 25) ? spq_pkg::CMD_ENQ : (r < 80) ? spq_pkg::CMD_DEQ :
				(r < 98) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
			default: c = (r < 45) ? spq_pkg::CMD_ENQ : (r < 80) ? spq_pkg::CMD_DEQ :
				(r < 97) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_CLEAR;
		endcase
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0:       p = spq_pkg::PRIO_W'($urandom);
			1:       p = spq_pkg::PRIO_W'(int'($urandom_range(0, 4)) - 2);
			2:       p = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: p = spq_pkg::PRIO_W'(int'($urandom_range(0, 200)) - 100);
		endcase
		offer(c, v, p);
	endtask

	initial begin
		int words;
		int phase;
		int kind;
		int len;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= spq_pkg::CMD_PEEK;
		value_in  <= '0;
		prio_in   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, fill past full with extreme and tied priorities, then drain
		offer(spq_pkg::CMD_DEQ,   32'h0,        16'sh0);
		offer(spq_pkg::CMD_PEEK,  32'h0,        16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'hffffffff, 16'sh7fff);
		offer(spq_pkg::CMD_ENQ,   32'h00000000, 16'sh8000);
		offer(spq_pkg::CMD_ENQ,   32'h55555555, 16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'haaaaaaaa, 16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'h00000001, 16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'h12345678, 16'shffff);
		offer(spq_pkg::CMD_ENQ,   32'h00000002, 16'sh7fff);
		offer(spq_pkg::CMD_ENQ,   32'h00000003, 16'sh1);
		offer(spq_pkg::CMD_ENQ,   32'h00000004, 16'shfffe);
		offer(spq_pkg::CMD_ENQ,   32'h00000005, 16'sh64);
		offer(spq_pkg::CMD_ENQ,   32'h00000006, 16'shff9c);
		offer(spq_pkg::CMD_ENQ,   32'h00000007, 16'sh8000);
		offer(spq_pkg::CMD_ENQ,   32'h00000008, 16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'h00000009, 16'sh4000);
		offer(spq_pkg::CMD_ENQ,   32'h0000000a, 16'shc000);
		offer(spq_pkg::CMD_ENQ,   32'h0000000b, 16'sh7ffe);
		offer(spq_pkg::CMD_ENQ,   32'hdeadbeef, 16'sh7fff);
		offer(spq_pkg::CMD_PEEK,  32'h0,        16'sh0);
		offer(spq_pkg::CMD_DEQ,   32'h0,        16'sh0);
		offer(spq_pkg::CMD_DEQ,   32'h0,        16'sh0);
		offer(spq_pkg::CMD_CLEAR, 32'h0,        16'sh0);
		offer(spq_pkg::CMD_DEQ,   32'h0,        16'sh0);
		offer(spq_pkg::CMD_ENQ,   32'hcafef00d, 16'sh1234);

		words = 0;
		phase = 0;
		while (words < RANDOM_WORDS) begin
			kind = $urandom_range(0, 2);
			len  = $urandom_range(20, 80);
			if (phase == 2 || phase == 7) begin
				kind     = 0;
				hold_req = 1'b1;
			end
			if (phase == 4 || (phase != 2 && phase != 7 && $urandom_range(0, 3) == 0))
				wait_drained();
			repeat (len) offer_random(kind);
			words += len;
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.pending_count() != 0)
			sb.flag("results still outstanding at end of run");
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
